// ===== rtl/keyboard_scancode_fifo_device_macros.svh =====
// Assertion helpers shared by the block
`ifndef KEYBOARD_SCANCODE_FIFO_DEVICE_MACROS_SVH
`define KEYBOARD_SCANCODE_FIFO_DEVICE_MACROS_SVH

// Check that a condition holds at every clock edge out of reset
`define KBD_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a consequent holds in the cycle of its antecedent
`define KBD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kbd_pkg.sv =====
package kbd_pkg;

    // Build-time defaults and fixed field widths
    localparam int FIFO_DEPTH_DEF = 16;
    localparam int ACTION_W       = 2;
    localparam int REG_INDEX_W    = 10;
    localparam int DATA_W         = 32;
    localparam int KEYCODE_W      = 8;
    localparam int ENTRY_W        = 9;
    localparam int DEPTH_REG_W    = 5;
    localparam int CFG_INDEX_W    = 4;

    // Item actions
    localparam logic [ACTION_W-1:0] ACT_KEY   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;

    // Bus word registers
    localparam logic [REG_INDEX_W-1:0] REG_ID    = 10'd0;
    localparam logic [REG_INDEX_W-1:0] REG_DATA  = 10'd1;
    localparam logic [REG_INDEX_W-1:0] REG_COUNT = 10'd2;
    localparam logic [REG_INDEX_W-1:0] REG_IE    = 10'd3;
    localparam logic [REG_INDEX_W-1:0] REG_SIZE  = 10'd4;

    // Configuration registers
    localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ID    = 4'd1;

    // Scancode constants
    localparam logic [KEYCODE_W-1:0]   KEY_PREFIX  = 8'hE0;
    localparam logic [DEPTH_REG_W-1:0] DEPTH_RESET = 5'd16;

    // Configuration register contents
    typedef struct packed {
        logic [DEPTH_REG_W-1:0] depth_raw;
        logic [DATA_W-1:0]      device_id;
    } t_cfg;

endpackage

// ===== rtl/keyboard_scancode_fifo_device.sv =====
// Results: a result is registered in the cycle after its input transfer; a pop of a
// non-empty FIFO goes through the RAM read register, then the output register.
// Throughput: one item per cycle while the result side is not stalled, except a pop
// of a non-empty FIFO, which holds the input side while the RAM read completes.
// Reset (synchronous, active low): pointers, count, prefix flag and interrupt
// enable clear, depth setting returns to 16, device ID to 0; the key store is not cleared.
`include "keyboard_scancode_fifo_device_macros.svh"

module keyboard_scancode_fifo_device #(
    parameter int FIFO_DEPTH = kbd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [kbd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [kbd_pkg::DATA_W-1:0]       i_cfg_data,
    // input item channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [kbd_pkg::ACTION_W-1:0]     i_action,
    input  logic [kbd_pkg::REG_INDEX_W-1:0]  i_reg_index,
    input  logic [kbd_pkg::DATA_W-1:0]       i_write_value,
    input  logic [kbd_pkg::KEYCODE_W-1:0]    i_keycode,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [kbd_pkg::DATA_W-1:0]       o_read_data,
    output logic                             o_irq_level,
    output logic                             o_bad_offset,
    output logic                             o_fifo_overflow
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int DW = kbd_pkg::DATA_W;
    localparam int EW = kbd_pkg::ENTRY_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POP  = 2'b10
    } t_state;

    kbd_pkg::t_cfg cfg;

    t_state              r_state;
    logic [PW-1:0]       r_rp, n_rp;
    logic [PW-1:0]       r_wp, n_wp;
    logic [CW-1:0]       r_count, n_count;
    logic                r_ext, n_ext;
    logic [DW-1:0]       r_ie, n_ie;

    logic                r_out_valid;
    logic [DW-1:0]       r_out_data;
    logic                r_out_irq;
    logic                r_out_bad;
    logic                r_out_ovf;

    logic [CW-1:0]       depth;
    logic                in_fire;
    logic                out_fire;
    logic                push_we;
    logic                pop_mem;
    logic [EW-1:0]       entry;
    logic [EW-1:0]       ram_rdata;
    logic [DW-1:0]       res_data;
    logic                res_bad;
    logic                res_ovf;
    logic                res_irq;

    // Step a ring pointer, wrapping at the depth in use
    function automatic logic [PW-1:0] ptr_adv(input logic [PW-1:0] p, input logic [CW-1:0] d);
        logic [PW-1:0] q;
        q = (CW'(p) >= d - CW'(1)) ? '0 : p + PW'(1);
        return q;
    endfunction

    // Configuration registers
    kbd_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Key store
    kbd_ram #(
        .WIDTH (EW),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire & push_we),
        .i_waddr (r_wp),
        .i_wdata (entry),
        .i_re    (in_fire & pop_mem),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    // Clamp the depth in use to 1..FIFO_DEPTH
    always_comb begin
        if (cfg.depth_raw == '0) begin
            depth = CW'(1);
        end else if (32'(cfg.depth_raw) > FIFO_DEPTH) begin
            depth = CW'(FIFO_DEPTH);
        end else begin
            depth = CW'(cfg.depth_raw);
        end
    end

    // Handshakes
    assign in_fire    = i_in_valid & o_in_ready;
    assign out_fire   = r_out_valid & i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);

    // Decode the item and work out the next state and its result
    always_comb begin
        n_ext    = r_ext;
        n_count  = r_count;
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_ie     = r_ie;
        push_we  = 1'b0;
        pop_mem  = 1'b0;
        entry    = {i_keycode[7], r_ext, i_keycode[6:0]};
        res_data = '0;
        res_bad  = 1'b0;
        res_ovf  = 1'b0;
        unique case (i_action)
            kbd_pkg::ACT_KEY: begin
                if (i_keycode == kbd_pkg::KEY_PREFIX && !r_ext) begin
                    n_ext = 1'b1;
                end else begin
                    n_ext = 1'b0;
                    if (r_count < depth) begin
                        push_we = 1'b1;
                        n_wp    = ptr_adv(r_wp, depth);
                        n_count = r_count + CW'(1);
                    end else begin
                        res_ovf = 1'b1;
                    end
                end
            end
            kbd_pkg::ACT_READ: begin
                unique case (i_reg_index)
                    kbd_pkg::REG_ID:    res_data = cfg.device_id;
                    kbd_pkg::REG_DATA: begin
                        if (r_count == '0) begin
                            res_data = '1;
                        end else begin
                            pop_mem = 1'b1;
                            n_rp    = ptr_adv(r_rp, depth);
                            n_count = r_count - CW'(1);
                        end
                    end
                    kbd_pkg::REG_COUNT: res_data = DW'(r_count);
                    kbd_pkg::REG_IE:    res_data = r_ie;
                    kbd_pkg::REG_SIZE:  res_data = DW'(depth);
                    default:            res_bad  = 1'b1;
                endcase
            end
            kbd_pkg::ACT_WRITE: begin
                if (i_reg_index == kbd_pkg::REG_IE) begin
                    n_ie = i_write_value;
                end else begin
                    res_bad = 1'b1;
                end
            end
            default: ;
        endcase
        res_irq = (n_count != '0) && (n_ie != '0);
    end

    // Control state: commit the item on its transfer, wait out the RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rp    <= '0;
            r_wp    <= '0;
            r_count <= '0;
            r_ext   <= 1'b0;
            r_ie    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_rp    <= n_rp;
                        r_wp    <= n_wp;
                        r_count <= n_count;
                        r_ext   <= n_ext;
                        r_ie    <= n_ie;
                        if (pop_mem) begin
                            r_state <= ST_POP;
                        end
                    end
                end
                ST_POP: r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Output register valid: load on a finished item, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && !pop_mem) begin
            r_out_valid <= 1'b1;
        end else if (r_state == ST_POP) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: flags at transfer, data at transfer or from the RAM
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_irq  <= res_irq;
            r_out_bad  <= res_bad;
            r_out_ovf  <= res_ovf;
            r_out_data <= res_data;
        end else if (r_state == ST_POP) begin
            r_out_data <= {ram_rdata[EW-1], {(DW - EW){1'b0}}, ram_rdata[EW-2:0]};
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_out_data;
    assign o_irq_level     = r_out_irq;
    assign o_bad_offset    = r_out_bad;
    assign o_fifo_overflow = r_out_ovf;

    // Assertions
    `KBD_ASSERT_IMPL(a_pop_slot_free, i_clk, i_rst_n, r_state == ST_POP, !r_out_valid, "pop read found output register busy")
    `KBD_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, 32'(r_count) <= FIFO_DEPTH, "entry count exceeds built depth")
    `KBD_ASSERT_IMPL(a_bad_no_data, i_clk, i_rst_n, o_out_valid && o_bad_offset, o_read_data == '0 && !o_fifo_overflow, "bad offset result carries data")

endmodule

// ===== rtl/kbd_ram.sv =====
module kbd_ram #(
    parameter int WIDTH = kbd_pkg::ENTRY_W,
    parameter int DEPTH = kbd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/kbd_regs.sv =====
module kbd_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [kbd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [kbd_pkg::DATA_W-1:0]       i_cfg_data,
    output kbd_pkg::t_cfg                    o_cfg
);

    logic [kbd_pkg::DEPTH_REG_W-1:0] r_depth;
    logic [kbd_pkg::DATA_W-1:0]      r_device_id;

    // Take a write in every cycle
    assign o_cfg_ready = 1'b1;

    // Decode and store configuration transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= kbd_pkg::DEPTH_RESET;
            r_device_id <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                kbd_pkg::CFG_DEPTH: r_depth     <= i_cfg_data[kbd_pkg::DEPTH_REG_W-1:0];
                kbd_pkg::CFG_ID:    r_device_id <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.depth_raw = r_depth;
    assign o_cfg.device_id = r_device_id;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // Package constants used here
    localparam int ACTION_W    = kbd_pkg::ACTION_W;
    localparam int REG_INDEX_W = kbd_pkg::REG_INDEX_W;
    localparam int DATA_W      = kbd_pkg::DATA_W;
    localparam int KEYCODE_W   = kbd_pkg::KEYCODE_W;
    localparam int ENTRY_W     = kbd_pkg::ENTRY_W;
    localparam int DEPTH_REG_W = kbd_pkg::DEPTH_REG_W;
    localparam int CFG_INDEX_W = kbd_pkg::CFG_INDEX_W;

    localparam logic [ACTION_W-1:0]    ACT_KEY     = kbd_pkg::ACT_KEY;
    localparam logic [ACTION_W-1:0]    ACT_READ    = kbd_pkg::ACT_READ;
    localparam logic [ACTION_W-1:0]    ACT_WRITE   = kbd_pkg::ACT_WRITE;
    localparam logic [REG_INDEX_W-1:0] REG_ID      = kbd_pkg::REG_ID;
    localparam logic [REG_INDEX_W-1:0] REG_DATA    = kbd_pkg::REG_DATA;
    localparam logic [REG_INDEX_W-1:0] REG_COUNT   = kbd_pkg::REG_COUNT;
    localparam logic [REG_INDEX_W-1:0] REG_IE      = kbd_pkg::REG_IE;
    localparam logic [REG_INDEX_W-1:0] REG_SIZE    = kbd_pkg::REG_SIZE;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH   = kbd_pkg::CFG_DEPTH;
    localparam logic [CFG_INDEX_W-1:0] CFG_ID      = kbd_pkg::CFG_ID;
    localparam logic [KEYCODE_W-1:0]   KEY_PREFIX  = kbd_pkg::KEY_PREFIX;
    localparam logic [DEPTH_REG_W-1:0] DEPTH_RESET = kbd_pkg::DEPTH_RESET;

    localparam logic [ACTION_W-1:0]    ACT_NONE   = 2'd3;
    localparam logic [REG_INDEX_W-1:0] REG_HOLE   = 10'd5;
    localparam logic [REG_INDEX_W-1:0] REG_LAST   = 10'd1023;
    localparam int                     RING_SLOTS = 16;
    localparam int                     DIR_ROWS   = 26;
    localparam int                     PHASES     = 6;
    localparam int                     PHASE_LEN  = 200;
    localparam int                     CYCLE_CAP  = 1000000;

    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic [REG_INDEX_W-1:0] reg_index;
        logic [DATA_W-1:0]      write_value;
        logic [KEYCODE_W-1:0]   keycode;
    } t_kbd_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_level;
        logic              bad_offset;
        logic              fifo_overflow;
    } t_kbd_result;

    typedef struct packed {
        t_kbd_item   item;
        logic        typed;
        t_kbd_result res;
    } t_dir_row;

    localparam t_kbd_result NO_RES = '0;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]      i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [ACTION_W-1:0]    i_action;
    logic [REG_INDEX_W-1:0] i_reg_index;
    logic [DATA_W-1:0]      i_write_value;
    logic [KEYCODE_W-1:0]   i_keycode;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [DATA_W-1:0]      o_read_data;
    logic                   o_irq_level;
    logic                   o_bad_offset;
    logic                   o_fifo_overflow;

    // Predicted device state
    logic [ENTRY_W-1:0]     scan_ring [RING_SLOTS];
    logic [3:0]             ring_head;
    logic [4:0]             ring_fill;
    logic                   prefix_armed;
    logic [DATA_W-1:0]      irq_mask;
    logic [DEPTH_REG_W-1:0] depth_setting;
    logic [DATA_W-1:0]      id_word;

    t_kbd_result expected_results [$];
    bit          failed;
    int          burst_left;
    int          cycle_count;

    // Directed rows: typed results only where obvious, the rest go through the predictor
    t_dir_row directed [DIR_ROWS] = '{
        '{'{ACT_READ,  REG_ID,    32'h0,        8'h00}, 1'b1, '{32'h0, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_READ,  REG_SIZE,  32'h0,        8'h00}, 1'b1, '{32'd16, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_READ,  REG_COUNT, 32'h0,        8'h00}, 1'b1, '{32'h0, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_READ,  REG_DATA,  32'h0,        8'h00}, 1'b1, '{32'hFFFFFFFF, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_READ,  REG_IE,    32'h0,        8'h00}, 1'b1, '{32'h0, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_WRITE, REG_IE,    32'hFFFFFFFF, 8'h00}, 1'b1, '{32'h0, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_KEY,   REG_ID,    32'h0,        8'h00}, 1'b0, NO_RES},
        '{'{ACT_KEY,   REG_LAST,  32'hFFFFFFFF, 8'hFF}, 1'b0, NO_RES},
        '{'{ACT_KEY,   REG_ID,    32'h0,        KEY_PREFIX}, 1'b0, NO_RES},
        '{'{ACT_KEY,   REG_ID,    32'h0,        8'h9C}, 1'b0, NO_RES},
        '{'{ACT_KEY,   REG_ID,    32'h0,        KEY_PREFIX}, 1'b0, NO_RES},
        '{'{ACT_KEY,   REG_ID,    32'h0,        KEY_PREFIX}, 1'b0, NO_RES},
        '{'{ACT_KEY,   REG_ID,    32'h0,        8'h1D}, 1'b0, NO_RES},
        '{'{ACT_READ,  REG_COUNT, 32'h0,        8'h00}, 1'b0, NO_RES},
        '{'{ACT_READ,  REG_HOLE,  32'h0,        8'h00}, 1'b1, '{32'h0, 1'b1, 1'b1, 1'b0}},
        '{'{ACT_READ,  REG_LAST,  32'h0,        8'h00}, 1'b1, '{32'h0, 1'b1, 1'b1, 1'b0}},
        '{'{ACT_WRITE, REG_ID,    32'hFFFFFFFF, 8'h00}, 1'b1, '{32'h0, 1'b1, 1'b1, 1'b0}},
        '{'{ACT_NONE,  REG_LAST,  32'hFFFFFFFF, 8'hFF}, 1'b1, '{32'h0, 1'b1, 1'b0, 1'b0}},
        '{'{ACT_READ,  REG_DATA,  32'h0,        8'h00}, 1'b0, NO_RES},
        '{'{ACT_READ,  REG_DATA,  32'h0,        8'h00}, 1'b0, NO_RES},
        '{'{ACT_READ,  REG_DATA,  32'h0,        8'h00}, 1'b0, NO_RES},
        '{'{ACT_READ,  REG_DATA,  32'h0,        8'h00}, 1'b0, NO_RES},
        '{'{ACT_READ,  REG_DATA,  32'h0,        8'h00}, 1'b0, NO_RES},
        '{'{ACT_READ,  REG_DATA,  32'h0,        8'h00}, 1'b1, '{32'hFFFFFFFF, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_WRITE, REG_IE,    32'h0,        8'h00}, 1'b1, '{32'h0, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_WRITE, REG_LAST,  32'h0,        8'h00}, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b0}}
    };

    keyboard_scancode_fifo_device dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_reg_index     (i_reg_index),
        .i_write_value   (i_write_value),
        .i_keycode       (i_keycode),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_data     (o_read_data),
        .o_irq_level     (o_irq_level),
        .o_bad_offset    (o_bad_offset),
        .o_fifo_overflow (o_fifo_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one item to the predicted state and return the response it should give
    function automatic t_kbd_result predict_response(t_kbd_item it);
        t_kbd_result        r;
        int                 depth;
        int                 slot;
        logic [ENTRY_W-1:0] entry;
        r = '0;
        depth = (depth_setting == 0) ? 1 :
                (depth_setting > RING_SLOTS) ? RING_SLOTS : int'(depth_setting);
        case (it.action)
            ACT_KEY: begin
                if (it.keycode == KEY_PREFIX && !prefix_armed) begin
                    prefix_armed = 1'b1;
                end else begin
                    entry = {it.keycode[7], prefix_armed, it.keycode[6:0]};
                    prefix_armed = 1'b0;
                    if (ring_fill < depth) begin
                        slot = ((int'(ring_head) % depth) + int'(ring_fill)) % depth;
                        scan_ring[slot] = entry;
                        ring_fill = ring_fill + 5'd1;
                    end else begin
                        r.fifo_overflow = 1'b1;
                    end
                end
            end
            ACT_READ: begin
                case (it.reg_index)
                    REG_ID:    r.read_data = id_word;
                    REG_DATA: begin
                        if (ring_fill == 0) begin
                            r.read_data = '1;
                        end else begin
                            slot = int'(ring_head) % depth;
                            entry = scan_ring[slot];
                            r.read_data = {entry[8], 23'd0, entry[7:0]};
                            ring_fill = ring_fill - 5'd1;
                            ring_head = 4'((slot + 1) % depth);
                        end
                    end
                    REG_COUNT: r.read_data = 32'(ring_fill);
                    REG_IE:    r.read_data = irq_mask;
                    REG_SIZE:  r.read_data = 32'(depth);
                    default:   r.bad_offset = 1'b1;
                endcase
            end
            ACT_WRITE: begin
                if (it.reg_index == REG_IE) begin
                    irq_mask = it.write_value;
                end else begin
                    r.bad_offset = 1'b1;
                end
            end
            default: ;
        endcase
        r.irq_level = (ring_fill != 0) && (irq_mask != 0);
        return r;
    endfunction

    // Sender gap: mostly none or short, a few long, with bursts of back-to-back items
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_kbd_item make_random_item(int key_pct);
        t_kbd_item it;
        int        r;
        it.action      = ACT_KEY;
        it.reg_index   = REG_INDEX_W'($urandom_range(0, 1023));
        it.write_value = $urandom;
        it.keycode     = KEYCODE_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < key_pct) begin
            if ($urandom_range(0, 99) < 20) it.keycode = KEY_PREFIX;
            return it;
        end
        r = $urandom_range(0, 99);
        if (r < 40) begin
            it.action    = ACT_READ;
            it.reg_index = REG_DATA;
        end else if (r < 65) begin
            it.action = ACT_READ;
            case ($urandom_range(0, 3))
                0:       it.reg_index = REG_ID;
                1:       it.reg_index = REG_COUNT;
                2:       it.reg_index = REG_IE;
                default: it.reg_index = REG_SIZE;
            endcase
        end else if (r < 80) begin
            it.action    = ACT_WRITE;
            it.reg_index = REG_IE;
            if ($urandom_range(0, 4) == 0) it.write_value = '0;
        end else if (r < 92) begin
            // undefined read offsets and writes to anything but the enable word
            if ($urandom_range(0, 1) == 0) begin
                it.action    = ACT_READ;
                it.reg_index = REG_INDEX_W'($urandom_range(5, 1023));
            end else begin
                it.action = ACT_WRITE;
                if (it.reg_index == REG_IE) it.reg_index = REG_HOLE;
            end
        end else begin
            it.action = ACT_NONE;
        end
        return it;
    endfunction

    // Present one item, hold it until the transfer, then queue its expected response
    task automatic send_item(input t_kbd_item it, input logic typed, input t_kbd_result res);
        int          gap;
        t_kbd_result pred;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_action      <= it.action;
        i_reg_index   <= it.reg_index;
        i_write_value <= it.write_value;
        i_keycode     <= it.keycode;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        pred = predict_response(it);
        expected_results.push_back(typed ? res : pred);
    endtask

    // Drop valid and wait until every expected response has come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one configuration register while the block is idle
    task automatic set_config(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
        t_kbd_item pop_item;
        // empty the ring first so a depth change cannot expose unwritten slots
        if (idx == CFG_DEPTH) begin
            while (ring_fill != 0) begin
                pop_item = '{ACT_READ, REG_DATA, $urandom, KEYCODE_W'($urandom_range(0, 255))};
                send_item(pop_item, 1'b0, NO_RES);
            end
        end
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == CFG_DEPTH) depth_setting = data[DEPTH_REG_W-1:0];
        else if (idx == CFG_ID) id_word = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls, mostly short, a few long, some long open stretches
    initial begin : out_ready_gen
        int   hold;
        logic level;
        hold = 0;
        level = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold == 0) begin
                level = ~level;
                if (!level) begin
                    hold = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3)
                                                        : $urandom_range(8, 40);
                end else begin
                    hold = ($urandom_range(0, 99) < 15) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 20);
                end
                i_out_ready <= level;
            end
            hold--;
        end
    end

    // Compare each response transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_kbd_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("response with no expectation pending: read_data %h", o_read_data);
                failed = 1'b1;
            end else begin
                want = expected_results.pop_front();
                if (o_read_data !== want.read_data) begin
                    $error("read_data: expected %h, actual %h", want.read_data, o_read_data);
                    failed = 1'b1;
                end
                if (o_irq_level !== want.irq_level) begin
                    $error("irq_level: expected %b, actual %b", want.irq_level, o_irq_level);
                    failed = 1'b1;
                end
                if (o_bad_offset !== want.bad_offset) begin
                    $error("bad_offset: expected %b, actual %b", want.bad_offset, o_bad_offset);
                    failed = 1'b1;
                end
                if (o_fifo_overflow !== want.fifo_overflow) begin
                    $error("fifo_overflow: expected %b, actual %b",
                           want.fifo_overflow, o_fifo_overflow);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int           ph;
        int           n;
        int           key_pct;
        logic [4:0]   depth_plan [PHASES];
        logic [31:0]  id_plan [PHASES];
        burst_left    = 0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_action      = ACT_KEY;
        i_reg_index   = '0;
        i_write_value = '0;
        i_keycode     = '0;
        ring_head     = '0;
        ring_fill     = '0;
        prefix_armed  = 1'b0;
        irq_mask      = '0;
        depth_setting = DEPTH_RESET;
        id_word       = '0;
        depth_plan = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd3, 5'($urandom_range(2, 15))};
        id_plan    = '{32'hFFFFFFFF, 32'h0, $urandom, 32'h80000001, $urandom, $urandom};

        // hold reset, then release on a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows against reset settings
        for (n = 0; n < DIR_ROWS; n++) begin
            send_item(directed[n].item, directed[n].typed, directed[n].res);
        end

        // random phases, each under its own depth and ID setting
        for (ph = 0; ph < PHASES; ph++) begin
            set_config(CFG_DEPTH, {27'($urandom_range(0, 32'h07FFFFFF)), depth_plan[ph]});
            set_config(CFG_ID, id_plan[ph]);
            key_pct = $urandom_range(30, 65);
            for (n = 0; n < PHASE_LEN; n++) begin
                send_item(make_random_item(key_pct), 1'b0, NO_RES);
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (!failed) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
